// ===== sv/onsel_pkg.sv =====
package onsel_pkg;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DRAIN,
    S_DECIDE,
    S_EMIT
  } onsel_state_t;

  localparam int unsigned NUM_OCTANTS  = 8;
  localparam int unsigned MIN_OCCUPIED = 6;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_SPARSE = 2'd1;
  localparam logic [1:0] STATUS_FEW    = 2'd2;

  localparam logic CFG_WANTED = 1'b0;
  localparam logic CFG_SKIP   = 1'b1;

  localparam logic [5:0] WANTED_RESET = 6'd16;

endpackage

// ===== sv/onsel_cell.sv =====
module onsel_cell import onsel_pkg::*; #(
  parameter int IDX_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             ins_en,
  input  logic             shift_en,
  input  logic [31:0]      new_dist,
  input  logic [2:0]       new_oct,
  input  logic [IDX_W-1:0] new_idx,
  input  logic             left_gt,
  input  logic             left_valid,
  input  logic [31:0]      left_dist,
  input  logic [2:0]       left_oct,
  input  logic [IDX_W-1:0] left_idx,
  input  logic             right_valid,
  input  logic [31:0]      right_dist,
  input  logic [2:0]       right_oct,
  input  logic [IDX_W-1:0] right_idx,
  output logic             gt,
  output logic             valid,
  output logic [31:0]      distance,
  output logic [2:0]       oct,
  output logic [IDX_W-1:0] idx
);

  logic             valid_r;
  logic [31:0]      dist_r;
  logic [2:0]       oct_r;
  logic [IDX_W-1:0] idx_r;

  // An empty cell counts as farther than any point, so the free tail fills in order.
  assign gt = !valid_r || (dist_r > new_dist);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift_en) begin
      valid_r <= right_valid;
    end else if (ins_en && gt) begin
      valid_r <= left_gt ? left_valid : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      dist_r <= right_dist;
      oct_r  <= right_oct;
      idx_r  <= right_idx;
    end else if (ins_en && gt) begin
      if (left_gt) begin
        dist_r <= left_dist;
        oct_r  <= left_oct;
        idx_r  <= left_idx;
      end else begin
        dist_r <= new_dist;
        oct_r  <= new_oct;
        idx_r  <= new_idx;
      end
    end
  end

  assign valid    = valid_r;
  assign distance = dist_r;
  assign oct      = oct_r;
  assign idx      = idx_r;

endmodule

// ===== sv/octant_neighbor_selector_core.sv =====
// Octant neighbor selector.
// Points arrive on the start/busy command channel: a point is taken at an edge
// where start is high and busy is low, one point per cycle while a run loads.
// Each point is registered into a chain of MAX_POINTS sorting cells, ties kept
// in arrival order. Points beyond MAX_POINTS are dropped.
// The point with in_last_point set ends the run. busy then stays high while the
// chain shifts its held points out to the octant selector, one per cycle, until
// it sees the chain empty; a decision state follows, and the emit scan walks
// 8 * PER_OCTANT_CAP slot/octant places, one per cycle. Results appear in the
// cycle after their scan place, marked by out_valid for one cycle each; the last
// result may still be on the ports in the first idle cycle.
// Busy stays high through the emit scan, or only up to the decision state when
// the run fails. A failed run gives a single word with status 1.
// The receiver cannot stall: every result must be taken when strobed.
// Reset empties the chain and sets wanted_neighbors to 16, skip_nearest to 0.
// The user is to write configuration through cfg_we/cfg_index/cfg_wdata only
// while idle; the block itself does not enforce this.
module octant_neighbor_selector_core import onsel_pkg::*; #(
  parameter int MAX_POINTS     = 256,
  parameter int PER_OCTANT_CAP = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_distance,
  input  logic [2:0]  in_octant,
  input  logic        in_last_point,
  output logic        out_valid,
  output logic        out_has_neighbor,
  output logic [7:0]  out_neighbor_index,
  output logic [31:0] out_neighbor_distance,
  output logic [1:0]  out_status,
  output logic        out_last_result,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_wdata
);

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SLOT_W = (PER_OCTANT_CAP > 1) ? $clog2(PER_OCTANT_CAP) : 1;
  localparam int ADDR_W = SLOT_W + 3;
  localparam int DEPTH  = 1 << ADDR_W;

  onsel_state_t state_r, state_nxt;

  logic [5:0]       wanted_r;
  logic             skip_r;
  logic [CNT_W-1:0] count_r;
  logic             full;

  logic ins_en, shift_en;

  // Chain wiring; index 0 is the nearest point.
  logic             c_gt    [MAX_POINTS];
  logic             c_valid [MAX_POINTS];
  logic [31:0]      c_dist  [MAX_POINTS];
  logic [2:0]       c_oct   [MAX_POINTS];
  logic [IDX_W-1:0] c_idx   [MAX_POINTS];

  assign full = (count_r == CNT_W'(MAX_POINTS));

  genvar g;
  generate
    for (g = 0; g < MAX_POINTS; g++) begin : g_cell
      logic             l_gt, l_valid, r_valid;
      logic [31:0]      l_dist, r_dist;
      logic [2:0]       l_oct, r_oct;
      logic [IDX_W-1:0] l_idx, r_idx;
      if (g == 0) begin : g_head
        assign l_gt    = 1'b0;
        assign l_valid = 1'b0;
        assign l_dist  = '0;
        assign l_oct   = '0;
        assign l_idx   = '0;
      end else begin : g_mid
        assign l_gt    = c_gt[g-1];
        assign l_valid = c_valid[g-1];
        assign l_dist  = c_dist[g-1];
        assign l_oct   = c_oct[g-1];
        assign l_idx   = c_idx[g-1];
      end
      if (g == MAX_POINTS - 1) begin : g_tail
        assign r_valid = 1'b0;
        assign r_dist  = '0;
        assign r_oct   = '0;
        assign r_idx   = '0;
      end else begin : g_body
        assign r_valid = c_valid[g+1];
        assign r_dist  = c_dist[g+1];
        assign r_oct   = c_oct[g+1];
        assign r_idx   = c_idx[g+1];
      end
      onsel_cell #(.IDX_W(IDX_W)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ins_en     (ins_en),
        .shift_en   (shift_en),
        .new_dist   (in_distance),
        .new_oct    (in_octant),
        .new_idx    (count_r[IDX_W-1:0]),
        .left_gt    (l_gt),
        .left_valid (l_valid),
        .left_dist  (l_dist),
        .left_oct   (l_oct),
        .left_idx   (l_idx),
        .right_valid(r_valid),
        .right_dist (r_dist),
        .right_oct  (r_oct),
        .right_idx  (r_idx),
        .gt         (c_gt[g]),
        .valid      (c_valid[g]),
        .distance   (c_dist[g]),
        .oct        (c_oct[g]),
        .idx        (c_idx[g])
      );
    end
  endgenerate

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_r <= WANTED_RESET;
      skip_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WANTED: wanted_r <= cfg_wdata;
        CFG_SKIP:   skip_r   <= cfg_wdata[0];
        default:    ;
      endcase
    end
  end

  logic accept;
  assign accept = start && !busy;

  // Selection state.
  logic [2:0]        fill_r [NUM_OCTANTS];
  logic [5:0]        kept_r;
  logic              skip_pend_r;
  logic [SLOT_W-1:0] slot_r;
  logic [2:0]        soct_r;
  logic [5:0]        issue_r;
  logic [1:0]        status_r;

  logic [2:0] head_oct;
  logic       head_take, head_store;
  logic [NUM_OCTANTS-1:0] occ;
  logic       sparse;
  logic       hit, scan_end;

  assign head_oct   = c_oct[0];
  assign head_take  = shift_en && c_valid[0];
  assign head_store = head_take && !skip_pend_r &&
                      (fill_r[head_oct] < 3'(PER_OCTANT_CAP));

  always_comb begin
    for (int i = 0; i < NUM_OCTANTS; i++) begin
      occ[i] = (fill_r[i] != 3'd0);
    end
  end
  assign sparse   = ($countones(occ) < MIN_OCCUPIED);
  assign hit      = (fill_r[soct_r] > 3'(slot_r));
  assign scan_end = (slot_r == SLOT_W'(PER_OCTANT_CAP - 1)) && (soct_r == 3'd7);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (accept && in_last_point) state_nxt = S_DRAIN;
      S_DRAIN:  if (!c_valid[0]) state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = sparse ? S_IDLE : S_EMIT;
      S_EMIT:   if (scan_end) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    busy     = 1'b1;
    ins_en   = 1'b0;
    shift_en = 1'b0;
    case (state_r)
      S_IDLE: begin
        busy   = 1'b0;
        ins_en = start && !full;
      end
      S_DRAIN: shift_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      kept_r      <= '0;
      skip_pend_r <= 1'b0;
      slot_r      <= '0;
      soct_r      <= '0;
      issue_r     <= '0;
      status_r    <= STATUS_OK;
      for (int i = 0; i < NUM_OCTANTS; i++) fill_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept && in_last_point) begin
        count_r     <= '0;
        kept_r      <= '0;
        skip_pend_r <= skip_r;
        for (int i = 0; i < NUM_OCTANTS; i++) fill_r[i] <= '0;
      end else if (ins_en) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (head_take) skip_pend_r <= 1'b0;
      if (head_store) begin
        fill_r[head_oct] <= fill_r[head_oct] + 3'd1;
        kept_r           <= kept_r + 6'd1;
      end
      if (state_r == S_DECIDE) begin
        slot_r   <= '0;
        soct_r   <= '0;
        issue_r  <= '0;
        status_r <= (kept_r > wanted_r) ? STATUS_OK : STATUS_FEW;
      end
      if (state_r == S_EMIT) begin
        soct_r <= soct_r + 3'd1;
        if (soct_r == 3'd7) slot_r <= slot_r + SLOT_W'(1);
        if (hit) issue_r <= issue_r + 6'd1;
      end
    end
  end

  // Slot memory: kept points by slot and octant.
  logic [IDX_W+31:0] slot_mem [DEPTH];
  logic [IDX_W+31:0] rd_r;
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  assign wr_addr = {fill_r[head_oct][SLOT_W-1:0], head_oct};
  assign rd_addr = {slot_r, soct_r};

  always_ff @(posedge clk) begin
    if (head_store) slot_mem[wr_addr] <= {c_idx[0], c_dist[0]};
    rd_r <= slot_mem[rd_addr];
  end

  // Result word registers.
  logic       ov_r, has_r, last_r, fail_r;
  logic [1:0] ost_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      has_r  <= 1'b0;
      last_r <= 1'b0;
      fail_r <= 1'b0;
      ost_r  <= STATUS_OK;
    end else begin
      ov_r   <= 1'b0;
      fail_r <= 1'b0;
      if (state_r == S_DECIDE && sparse) begin
        ov_r   <= 1'b1;
        has_r  <= 1'b0;
        last_r <= 1'b1;
        fail_r <= 1'b1;
        ost_r  <= STATUS_SPARSE;
      end else if (state_r == S_EMIT && hit) begin
        ov_r   <= 1'b1;
        has_r  <= 1'b1;
        last_r <= ((issue_r + 6'd1) == kept_r);
        ost_r  <= status_r;
      end
    end
  end

  assign out_valid             = ov_r;
  assign out_has_neighbor      = has_r;
  assign out_status            = ost_r;
  assign out_last_result       = last_r;
  assign out_neighbor_index    = fail_r ? 8'd0 : 8'(rd_r[IDX_W+31:32]);
  assign out_neighbor_distance = fail_r ? 32'd0 : rd_r[31:0];

`ifndef SYNTHESIS
  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r[head_oct] <= 3'(PER_OCTANT_CAP)))
    else $error("octant fill beyond cap");
  a_fail_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_neighbor) |-> (out_status == STATUS_SPARSE && out_last_result))
    else $error("failed run word malformed");
  a_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE) |-> (!c_valid[0] && count_r == '0))
    else $error("chain not empty after drain");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CNT_W'(MAX_POINTS)))
    else $error("point count overflow");
`endif

endmodule

// ===== sim/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import onsel_pkg::*;

  localparam int unsigned POINT_CAP = 256;
  localparam int unsigned OCT_CAP   = 6;
  localparam int unsigned WATCHDOG  = 4000;

  typedef struct packed {
    logic        has;
    logic [7:0]  idx;
    logic [31:0] distance;
    logic [1:0]  status;
    logic        last;
  } word_t;

  typedef struct packed {
    logic [31:0] distance;
    logic [2:0]  oct;
    logic [7:0]  idx;
  } point_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_distance;
  logic [2:0]  in_octant;
  logic        in_last_point;
  logic        out_valid;
  logic        out_has_neighbor;
  logic [7:0]  out_neighbor_index;
  logic [31:0] out_neighbor_distance;
  logic [1:0]  out_status;
  logic        out_last_result;
  logic        cfg_we;
  logic        cfg_index;
  logic [5:0]  cfg_wdata;

  octant_neighbor_selector_core dut (.*);

  word_t       pending_words[$];
  point_t      held_points[$];
  int unsigned arrivals;
  logic [5:0]  wanted_q;
  logic        skip_q;
  int unsigned mismatches;
  int unsigned idle_cycles;
  bit          fed_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stable insertion: a new point goes after every held point of no greater distance.
  task automatic take_point(input logic [31:0] d, input logic [2:0] o, input logic lst,
                            input bit use_table, input word_t tw);
    int unsigned pos;
    int unsigned fill[8];
    int          slot_of[OCT_CAP][8];
    int unsigned occupied;
    int unsigned kept;
    int unsigned n;
    logic [1:0]  st;
    point_t      p;
    word_t       w;
    if (held_points.size() < POINT_CAP) begin
      pos = held_points.size();
      while (pos > 0 && held_points[pos-1].distance > d) pos--;
      p.distance = d;
      p.oct = o;
      p.idx = arrivals[7:0];
      held_points.insert(pos, p);
      arrivals++;
    end
    if (!lst) return;
    occupied = 0;
    kept = 0;
    n = 0;
    foreach (fill[i]) fill[i] = 0;
    for (int s = skip_q ? 1 : 0; s < held_points.size(); s++) begin
      if (fill[held_points[s].oct] < OCT_CAP) begin
        slot_of[fill[held_points[s].oct]][held_points[s].oct] = s;
        fill[held_points[s].oct]++;
        kept++;
      end
    end
    foreach (fill[i]) if (fill[i] != 0) occupied++;
    if (occupied < MIN_OCCUPIED) begin
      w = '{1'b0, 8'd0, 32'd0, STATUS_SPARSE, 1'b1};
      if (use_table && w != tw) begin
        mismatches++;
        if (mismatches <= 10) $display("table row: expected %h predicted %h", tw, w);
      end
      pending_words.push_back(w);
    end else begin
      st = (kept > wanted_q) ? STATUS_OK : STATUS_FEW;
      for (int s = 0; s < OCT_CAP; s++)
        for (int oc = 0; oc < 8; oc++)
          if (s < fill[oc]) begin
            p = held_points[slot_of[s][oc]];
            n++;
            w = '{1'b1, p.idx, p.distance, st, n == kept};
            pending_words.push_back(w);
          end
    end
    held_points.delete();
    arrivals = 0;
  endtask

  always @(posedge clk) begin
    word_t got;
    word_t exp_w;
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid) begin
        got = '{out_has_neighbor, out_neighbor_index, out_neighbor_distance,
                out_status, out_last_result};
        if (pending_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %h", got);
        end else begin
          exp_w = pending_words.pop_front();
          if (got !== exp_w) begin
            mismatches++;
            if (mismatches <= 10) $display("word mismatch: expected %h actual %h", exp_w, got);
          end
        end
      end
      if (out_valid || (start && !busy) || fed_done && pending_words.size() == 0)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic write_cfg(input logic idx, input logic [5:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WANTED) wanted_q = val;
    else skip_q = val[0];
  endtask

  task automatic settle();
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8 * OCT_CAP + POINT_CAP + 8) @(posedge clk);
  endtask

  // Drives one word and holds start until the block takes it.
  task automatic send_point(input logic [31:0] d, input logic [2:0] o, input logic lst,
                            input bit use_table, input word_t tw, input bit gaps);
    int unsigned gap;
    gap = gaps ? $urandom_range(0, 8) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_distance <= d;
    in_octant <= o;
    in_last_point <= lst;
    do @(posedge clk); while (busy);
    take_point(d, o, lst, use_table, tw);
  endtask

  typedef struct {
    logic [31:0] d;
    logic [2:0]  o;
    logic        lst;
    bit          typed;
    word_t       w;
  } row_t;

  task automatic run_set(input int unsigned cnt, input int unsigned spread);
    logic [31:0] d;
    for (int i = 0; i < cnt; i++) begin
      case ($urandom_range(0, 3))
        0: d = $urandom;
        1: d = $urandom_range(0, 7);
        2: d = 32'hFFFF_FFF8 | $urandom_range(0, 7);
        default: d = $urandom_range(0, 1000);
      endcase
      send_point(d, 3'($urandom_range(0, spread)), i == cnt - 1, 1'b0, '0, 1'b1);
    end
    start <= 1'b0;
  endtask

  row_t rows[$];

  initial begin
    word_t sparse;
    int unsigned fed;
    mismatches = 0;
    arrivals = 0;
    fed_done = 1'b0;
    wanted_q = WANTED_RESET;
    skip_q = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_distance = '0;
    in_octant = '0;
    in_last_point = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_WANTED;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sparse = '{1'b0, 8'd0, 32'd0, STATUS_SPARSE, 1'b1};
    // A single point after reset fails the occupancy test.
    rows.push_back('{32'hFFFF_FFFF, 3'd7, 1'b1, 1'b1, sparse});
    // Six octants with ties and extreme distances, too few for the reset count.
    rows.push_back('{32'd0, 3'd0, 1'b0, 1'b0, '0});
    rows.push_back('{32'hFFFF_FFFF, 3'd1, 1'b0, 1'b0, '0});
    rows.push_back('{32'd5, 3'd2, 1'b0, 1'b0, '0});
    rows.push_back('{32'd5, 3'd3, 1'b0, 1'b0, '0});
    rows.push_back('{32'd5, 3'd4, 1'b0, 1'b0, '0});
    rows.push_back('{32'd0, 3'd5, 1'b0, 1'b0, '0});
    rows.push_back('{32'h8000_0000, 3'd5, 1'b1, 1'b0, '0});
    // Five octants only.
    for (int i = 0; i < 5; i++) rows.push_back('{i, i[2:0], i == 4, i == 4, sparse});
    // Eight in one octant: only six are kept, still sparse.
    for (int i = 0; i < 8; i++) rows.push_back('{8 - i, 3'd6, i == 7, i == 7, sparse});
    foreach (rows[i]) send_point(rows[i].d, rows[i].o, rows[i].lst, rows[i].typed,
                                 rows[i].w, 1'b0);
    start <= 1'b0;
    settle();

    // Several settings, extremes among them; sets are small.
    fed = 0;
    while (fed < 14) begin
      case ($urandom_range(0, 5))
        0: write_cfg(CFG_WANTED, 6'd0);
        1: write_cfg(CFG_WANTED, 6'd63);
        2: write_cfg(CFG_WANTED, 6'($urandom_range(0, 48)));
        3: write_cfg(CFG_SKIP, 6'($urandom_range(0, 1)));
        default: ;
      endcase
      if ($urandom_range(0, 9) == 0) begin
        // Skip with a single point.
        write_cfg(CFG_SKIP, 6'd1);
        run_set(1, 7);
        fed++;
      end else begin
        int unsigned cnt;
        cnt = $urandom_range(6, 16);
        run_set(cnt, $urandom_range(0, 4) == 0 ? 4 : 7);
        fed += cnt;
      end
      settle();
    end
    // One overfilled set to reach the store limit.
    write_cfg(CFG_SKIP, 6'd0);
    run_set(POINT_CAP + 4, 7);
    settle();

    fed_done = 1'b1;
    if (mismatches == 0 && pending_words.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/onsel_pkg.sv
sv/onsel_cell.sv
sv/octant_neighbor_selector_core.sv
sim/testbench.sv
